/* rtl/ptm_pkg.sv */
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types, sizes, status codes and the control store of the page table
// map/unmap engine.
// ----------------------------------------------------------------------------
package ptm_pkg;

    localparam int TABLE_FRAMES = 16;
    localparam int ENTRY_W      = 64;
    localparam int IDX_W        = 9;
    localparam int FRAME_W      = $clog2(TABLE_FRAMES);
    localparam int ADDR_W       = FRAME_W + IDX_W;
    localparam int DEPTH        = TABLE_FRAMES * (1 << IDX_W);
    localparam int NFF_W        = $clog2(TABLE_FRAMES + 1);
    localparam int MEM_W        = ENTRY_W + 1;
    localparam int PFN_W        = 40;
    localparam int VA_W         = 48;
    localparam int PA_W         = 52;
    localparam int PG_W         = 12;
    localparam int ST_W         = 3;
    localparam int LVL_W        = 2;

    localparam logic [PFN_W-1:0] BASE_RESET = PFN_W'(256);

    localparam logic [ST_W-1:0] ST_DONE        = ST_W'(0);
    localparam logic [ST_W-1:0] ST_REFUSED     = ST_W'(1);
    localparam logic [ST_W-1:0] ST_UNALIGNED   = ST_W'(2);
    localparam logic [ST_W-1:0] ST_NO_FRAMES   = ST_W'(3);
    localparam logic [ST_W-1:0] ST_NOT_MAPPED  = ST_W'(4);
    localparam logic [ST_W-1:0] ST_BAD_POINTER = ST_W'(5);

    localparam logic [LVL_W-1:0] LVL_LAST_LINK = LVL_W'(2);

    typedef enum logic [2:0] {
        U_CLEAR,
        U_IDLE,
        U_CHECK,
        U_READ,
        U_EVAL,
        U_LINK,
        U_LEAF,
        U_FINISH
    } t_uop;

    typedef enum logic [2:0] {
        C_SEQ,
        C_HOLD_CLR,
        C_HOLD_IN,
        C_LOOP,
        C_HOLD_OUT
    } t_cond;

    typedef logic [3:0] t_step;

    localparam t_step STEP_CLEAR   = 4'd0;
    localparam t_step STEP_IDLE    = 4'd1;
    localparam t_step STEP_CHECK   = 4'd2;
    localparam t_step STEP_RD      = 4'd3;
    localparam t_step STEP_EV      = 4'd4;
    localparam t_step STEP_LINK    = 4'd5;
    localparam t_step STEP_LEAF_RD = 4'd6;
    localparam t_step STEP_LEAF_EV = 4'd7;
    localparam t_step STEP_FIN     = 4'd8;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic clr_done;
        logic in_fire;
        logic fail;
        logic more;
        logic out_free;
    } t_dp_stat;

    // control store
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        case (s)
            STEP_CLEAR:   w = '{U_CLEAR,  C_HOLD_CLR, STEP_IDLE};
            STEP_IDLE:    w = '{U_IDLE,   C_HOLD_IN,  STEP_CHECK};
            STEP_CHECK:   w = '{U_CHECK,  C_SEQ,      STEP_RD};
            STEP_RD:      w = '{U_READ,   C_SEQ,      STEP_EV};
            STEP_EV:      w = '{U_EVAL,   C_SEQ,      STEP_LINK};
            STEP_LINK:    w = '{U_LINK,   C_LOOP,     STEP_RD};
            STEP_LEAF_RD: w = '{U_READ,   C_SEQ,      STEP_LEAF_EV};
            STEP_LEAF_EV: w = '{U_LEAF,   C_SEQ,      STEP_FIN};
            STEP_FIN:     w = '{U_FINISH, C_HOLD_OUT, STEP_IDLE};
            default:      w = '{U_FINISH, C_HOLD_OUT, STEP_IDLE};
        endcase
        return w;
    endfunction

    // 9-bit table index for a level, level 0 is the root
    function automatic logic [IDX_W-1:0] slice_of(input logic [VA_W-1:0] va,
                                                  input logic [LVL_W-1:0] lvl);
        logic [IDX_W-1:0] s;
        unique case (lvl)
            2'd0:    s = va[47:39];
            2'd1:    s = va[38:30];
            2'd2:    s = va[29:21];
            default: s = va[20:12];
        endcase
        return s;
    endfunction

endpackage

/* rtl/ptm_req_if.sv */
// ----------------------------------------------------------------------------
// ptm_req_if
// Request channel: one map or unmap word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptm_req_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [ptm_pkg::VA_W-1:0]        virt_addr;
    logic [ptm_pkg::PA_W-1:0]        phys_addr;
    logic [ptm_pkg::ENTRY_W-1:0]     top_link_flags;
    logic [ptm_pkg::ENTRY_W-1:0]     mid_link_flags;
    logic [ptm_pkg::ENTRY_W-1:0]     low_link_flags;
    logic [ptm_pkg::ENTRY_W-1:0]     page_flags;
    logic                            allow_override;

    modport source (
        output valid, req_type, virt_addr, phys_addr, top_link_flags,
               mid_link_flags, low_link_flags, page_flags, allow_override,
        input  ready
    );
    modport sink (
        input  valid, req_type, virt_addr, phys_addr, top_link_flags,
               mid_link_flags, low_link_flags, page_flags, allow_override,
        output ready
    );
endinterface

/* rtl/ptm_rsp_if.sv */
// ----------------------------------------------------------------------------
// ptm_rsp_if
// Response channel: status and TLB invalidate word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ptm_pkg::ST_W-1:0]    status;
    logic                        invalidate;
    logic [ptm_pkg::VA_W-1:0]    invalidate_addr;

    modport source (
        output valid, status, invalidate, invalidate_addr,
        input  ready
    );
    modport sink (
        input  valid, status, invalidate, invalidate_addr,
        output ready
    );
endinterface

/* rtl/ptm_ram.sv */
// ----------------------------------------------------------------------------
// ptm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ptm_useq.sv */
// ----------------------------------------------------------------------------
// ptm_useq
// Microcode sequencer: step counter over the control store with
// conditional holds and jumps driven by datapath status.
// ----------------------------------------------------------------------------
module ptm_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptm_pkg::t_dp_stat i_stat,
    output ptm_pkg::t_uop     o_uop
);

    ptm_pkg::t_step  r_step;
    ptm_pkg::t_step  n_step;
    ptm_pkg::t_uword w_word;

    assign w_word = ptm_pkg::ucode(r_step);
    assign o_uop  = w_word.op;

    always_comb begin
        n_step = r_step;
        if (i_stat.fail) begin
            n_step = ptm_pkg::STEP_FIN;
        end else begin
            unique case (w_word.cond)
                ptm_pkg::C_SEQ:      n_step = r_step + 1'b1;
                ptm_pkg::C_HOLD_CLR: n_step = i_stat.clr_done ? w_word.target : r_step;
                ptm_pkg::C_HOLD_IN:  n_step = i_stat.in_fire ? w_word.target : r_step;
                ptm_pkg::C_LOOP:     n_step = i_stat.more ? w_word.target : r_step + 1'b1;
                ptm_pkg::C_HOLD_OUT: n_step = i_stat.out_free ? w_word.target : r_step;
                default:             n_step = ptm_pkg::STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ptm_pkg::STEP_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* rtl/ptm_dpath.sv */
// ----------------------------------------------------------------------------
// ptm_dpath
// Walk datapath: request registers, table store, frame allocator, pointer
// decode and the response register, steered by the current micro-op.
// ----------------------------------------------------------------------------
module ptm_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ptm_pkg::t_uop               i_uop,
    output ptm_pkg::t_dp_stat           o_stat,
    ptm_req_if.sink                     i_req,
    ptm_rsp_if.source                   o_rsp,
    input  logic                        i_cfg_we,
    input  logic [ptm_pkg::PFN_W-1:0]   i_cfg_data
);

    localparam int FRAME_W = ptm_pkg::FRAME_W;
    localparam int ADDR_W  = ptm_pkg::ADDR_W;
    localparam int NFF_W   = ptm_pkg::NFF_W;
    localparam int PFN_W   = ptm_pkg::PFN_W;
    localparam int ENTRY_W = ptm_pkg::ENTRY_W;
    localparam int MEM_W   = ptm_pkg::MEM_W;
    localparam int VA_W    = ptm_pkg::VA_W;
    localparam int PA_W    = ptm_pkg::PA_W;
    localparam int PG_W    = ptm_pkg::PG_W;
    localparam int ST_W    = ptm_pkg::ST_W;
    localparam int LVL_W   = ptm_pkg::LVL_W;

    // request
    logic                r_unmap;
    logic [VA_W-1:0]     r_va;
    logic [PA_W-1:0]     r_pa;
    logic [ENTRY_W-1:0]  r_lflags [3];
    logic [ENTRY_W-1:0]  r_pflags;
    logic                r_ovr;

    // walk
    logic [LVL_W-1:0]    r_lvl;
    logic [FRAME_W-1:0]  r_frame;
    logic [NFF_W-1:0]    r_nff;
    logic [PFN_W-1:0]    r_base;
    logic [ADDR_W-1:0]   r_clr;
    logic                r_ezero;
    logic [PFN_W-1:0]    r_rel;
    logic [PFN_W-1:0]    r_pfn;
    logic [ST_W-1:0]     r_status;
    logic                r_inval;

    // response
    logic                r_out_valid;
    logic [ST_W-1:0]     r_out_status;
    logic                r_out_inval;
    logic [VA_W-1:0]     r_out_addr;

    logic                w_in_ready;
    logic                w_in_fire;
    logic                w_out_free;
    logic [ptm_pkg::IDX_W-1:0] w_slice;
    logic [ADDR_W-1:0]   w_pos;
    logic                w_alloc;
    logic [MEM_W-1:0]    w_rword;
    logic [ENTRY_W-1:0]  w_entry;
    logic                w_zero;
    logic                w_unaligned;
    logic                w_full;
    logic                w_rel_bad;
    logic                w_do_alloc;
    logic                w_fail;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [MEM_W-1:0]    w_wdata;
    logic                w_re;

    assign w_in_ready  = (i_uop == ptm_pkg::U_IDLE);
    assign w_in_fire   = i_req.valid & w_in_ready;
    assign i_req.ready = w_in_ready;
    assign w_out_free  = ~r_out_valid | o_rsp.ready;

    assign w_slice = ptm_pkg::slice_of(r_va, r_lvl);
    assign w_pos   = {r_frame, w_slice};
    // entries written before their frame was allocated read as zero
    assign w_alloc = NFF_W'(r_frame) < r_nff;
    assign w_entry = (w_alloc && !w_rword[ENTRY_W]) ? '0 : w_rword[ENTRY_W-1:0];
    assign w_zero  = (w_entry == '0);

    assign w_unaligned = (|r_va[PG_W-1:0]) | (~r_unmap & (|r_pa[PG_W-1:0]));
    assign w_full      = r_nff >= NFF_W'(ptm_pkg::TABLE_FRAMES);
    assign w_rel_bad   = r_rel >= PFN_W'(ptm_pkg::TABLE_FRAMES);
    assign w_do_alloc  = r_ezero & ~r_unmap & ~w_full;

    assign w_fail = ((i_uop == ptm_pkg::U_CHECK) & w_unaligned)
                  | ((i_uop == ptm_pkg::U_LINK)
                     & (r_ezero ? (r_unmap | w_full) : w_rel_bad));

    assign o_stat.clr_done = (i_uop == ptm_pkg::U_CLEAR)
                           & (r_clr == ADDR_W'(ptm_pkg::DEPTH - 1));
    assign o_stat.in_fire  = w_in_fire;
    assign o_stat.fail     = w_fail;
    assign o_stat.more     = (r_lvl != ptm_pkg::LVL_LAST_LINK);
    assign o_stat.out_free = w_out_free;

    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = w_pos;
        w_wdata = '0;
        unique case (i_uop)
            ptm_pkg::U_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
            end
            ptm_pkg::U_READ: begin
                w_re = 1'b1;
            end
            ptm_pkg::U_LINK: begin
                // a link written into the frame being allocated now survives its clear
                w_we    = w_do_alloc;
                w_wdata = {NFF_W'(r_frame) <= r_nff,
                           ENTRY_W'({r_pfn, {PG_W{1'b0}}}) | r_lflags[r_lvl]};
            end
            ptm_pkg::U_LEAF: begin
                if (r_unmap) begin
                    w_we    = ~w_zero;
                    w_wdata = {w_alloc, {ENTRY_W{1'b0}}};
                end else begin
                    w_we    = w_zero | r_ovr;
                    w_wdata = {w_alloc, ENTRY_W'(r_pa) | r_pflags};
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    ptm_ram #(
        .WIDTH (MEM_W),
        .DEPTH (ptm_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_pos),
        .o_rdata (w_rword)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_nff       <= NFF_W'(1);
            r_base      <= ptm_pkg::BASE_RESET;
            r_out_valid <= 1'b0;
            r_lvl       <= '0;
            r_frame     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (i_uop == ptm_pkg::U_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_in_fire) begin
                r_lvl   <= '0;
                r_frame <= '0;
            end
            if (i_uop == ptm_pkg::U_LINK && !w_fail) begin
                r_lvl <= r_lvl + 1'b1;
                if (r_ezero) begin
                    r_frame <= r_nff[FRAME_W-1:0];
                    r_nff   <= r_nff + 1'b1;
                end else begin
                    r_frame <= r_rel[FRAME_W-1:0];
                end
            end
            if (i_uop == ptm_pkg::U_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_unmap     <= i_req.req_type;
            r_va        <= i_req.virt_addr;
            r_pa        <= i_req.phys_addr;
            r_lflags[0] <= i_req.top_link_flags;
            r_lflags[1] <= i_req.mid_link_flags;
            r_lflags[2] <= i_req.low_link_flags;
            r_pflags    <= i_req.page_flags;
            r_ovr       <= i_req.allow_override;
            r_inval     <= 1'b0;
        end
        if (i_uop == ptm_pkg::U_CHECK) begin
            r_status <= w_unaligned ? ptm_pkg::ST_UNALIGNED : ptm_pkg::ST_DONE;
        end
        if (i_uop == ptm_pkg::U_EVAL) begin
            r_ezero <= w_zero;
            r_rel   <= w_entry[PA_W-1:PG_W] - r_base;
            r_pfn   <= r_base + PFN_W'(r_nff);
        end
        if (i_uop == ptm_pkg::U_LINK) begin
            if (r_ezero) begin
                if (r_unmap) begin
                    r_status <= ptm_pkg::ST_NOT_MAPPED;
                end else if (w_full) begin
                    r_status <= ptm_pkg::ST_NO_FRAMES;
                end
            end else if (w_rel_bad) begin
                r_status <= ptm_pkg::ST_BAD_POINTER;
            end
        end
        if (i_uop == ptm_pkg::U_LEAF) begin
            if (r_unmap) begin
                if (w_zero) begin
                    r_status <= ptm_pkg::ST_NOT_MAPPED;
                end else begin
                    r_inval <= 1'b1;
                end
            end else if (w_zero || r_ovr) begin
                r_inval <= 1'b1;
            end else begin
                r_status <= ptm_pkg::ST_REFUSED;
            end
        end
        if (i_uop == ptm_pkg::U_FINISH && w_out_free) begin
            r_out_status <= r_status;
            r_out_inval  <= r_inval;
            r_out_addr   <= r_inval ? r_va : '0;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.invalidate      = r_out_inval;
    assign o_rsp.invalidate_addr = r_out_addr;

endmodule

/* rtl/page_table_map_unmap.sv */
// After reset the table store is swept to zero one entry per cycle, all 8192
// entries (TABLE_FRAMES * 512), before the first request word is taken;
// the base register may be written during the sweep. Each request is handled
// alone: accept, alignment check, then three link levels, each a store read,
// its registered read data and a decode or allocate step, then a store read
// and an update at the leaf; a failed check or link goes straight to finish,
// which loads the response once the output register is free. The next word
// can be taken in the cycle after the load. The single store port and its
// registered read set the split of each level into these steps. A new request
// is accepted while the previous response still waits in the output register.
// ----------------------------------------------------------------------------
// page_table_map_unmap
// Four-level page table map/unmap engine built as a microcoded sequencer
// driving a walk datapath over a private table store.
// ----------------------------------------------------------------------------
module page_table_map_unmap (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ptm_req_if.sink                     i_req,
    ptm_rsp_if.source                   o_rsp,
    input  logic                        i_cfg_we,
    input  logic [ptm_pkg::PFN_W-1:0]   i_cfg_data
);

    ptm_pkg::t_uop     w_uop;
    ptm_pkg::t_dp_stat w_stat;

    ptm_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uop   (w_uop)
    );

    ptm_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uop      (w_uop),
        .o_stat     (w_stat),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

`ifndef SYNTHESIS
    a_load_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(w_uop == ptm_pkg::U_FINISH))
        else $error("response loaded outside finish step");

    a_accept_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.in_fire |=> w_uop == ptm_pkg::U_CHECK)
        else $error("accepted word not followed by check step");

    a_fail_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.fail |-> (w_uop == ptm_pkg::U_CHECK || w_uop == ptm_pkg::U_LINK))
        else $error("failure flagged in a step that cannot fail");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_uop == ptm_pkg::U_CLEAR |-> !i_req.ready)
        else $error("request accepted during store clear");
`endif

endmodule

/* tb/page_table_map_unmap_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_map_unmap_tb
// Self-checking bench for the four-level page table engine. A table of
// directed words walks the error codes, frame exhaustion and link flags that
// corrupt pointers. Random words follow, mostly on a few known table paths,
// over phases that move the table base and vary sender gaps and receiver
// stalls. Each response word is checked against its directed row's expected
// result, if given, or an in-bench walk of a private copy of the table store.
// ----------------------------------------------------------------------------
module page_table_map_unmap_tb;
    import ptm_pkg::*;

    localparam logic REQ_MAP   = 1'b0;
    localparam logic REQ_UNMAP = 1'b1;

    localparam int SLOTS           = 1 << IDX_W;
    localparam int WORDS_PER_PHASE = 250;
    localparam int N_PHASES        = 6;
    localparam int MAX_REPORTS     = 10;

    localparam logic [PFN_W-1:0]   BASE_MAX     = '1;
    localparam logic [ENTRY_W-1:0] ALL_ONES     = '1;
    localparam logic [ENTRY_W-1:0] NO_ADDR_BITS = 64'hFFF0_0000_0000_0FFF;
    localparam logic [ENTRY_W-1:0] PFN_BIT12    = 64'h0000_0000_0100_0000;
    localparam logic [PA_W-1:0]    PA_TOP       = 52'hF_FFFF_FFFF_F000;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SRC_GAPS,
        PACE_SNK_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct packed {
        logic               req_type;
        logic [VA_W-1:0]    virt_addr;
        logic [PA_W-1:0]    phys_addr;
        logic [ENTRY_W-1:0] top_flags;
        logic [ENTRY_W-1:0] mid_flags;
        logic [ENTRY_W-1:0] low_flags;
        logic [ENTRY_W-1:0] page_flags;
        logic               allow_override;
    } map_req_t;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic            invalidate;
        logic [VA_W-1:0] inv_addr;
    } walk_result_t;

    typedef struct {
        map_req_t     word;
        logic         typed;
        walk_result_t want;
    } stim_row_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [PFN_W-1:0] cfg_data;

    ptm_req_if req_bus();
    ptm_rsp_if rsp_bus();

    page_table_map_unmap u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // shadow of the table store and allocator
    logic [ENTRY_W-1:0] frame_mem [DEPTH];
    int unsigned        frames_used;
    logic [PFN_W-1:0]   base_pfn;

    walk_result_t walk_results_q [$];
    stim_row_t    directed_rows [$];

    int unsigned src_gap_pct;
    int unsigned snk_stall_pct;
    int unsigned err_count;
    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned status_seen [8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(6_000_000);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [VA_W-1:0] va_of(input int unsigned s0, s1, s2, s3);
        return {9'(s0), 9'(s1), 9'(s2), 9'(s3), 12'h000};
    endfunction

    function automatic logic [IDX_W-1:0] corner_slot();
        int unsigned c;
        c = $urandom_range(0, 3);
        return (c == 3) ? 9'd511 : 9'(c);
    endfunction

    function automatic void add_row(input logic rt, input logic [VA_W-1:0] va,
                                    input logic [PA_W-1:0] pa,
                                    input logic [ENTRY_W-1:0] top, mid, low, pg,
                                    input logic ovr, input logic typed,
                                    input logic [ST_W-1:0] st, input logic inv);
        stim_row_t row;
        row.word  = '{rt, va, pa, top, mid, low, pg, ovr};
        row.typed = typed;
        row.want  = '{st, inv, inv ? va : VA_W'(0)};
        directed_rows.push_back(row);
    endfunction

    function automatic walk_result_t walk_tables(input map_req_t w);
        walk_result_t       r;
        logic [ENTRY_W-1:0] link [3];
        logic [ENTRY_W-1:0] entry;
        logic [PFN_W-1:0]   rel;
        logic [IDX_W-1:0]   slot;
        int unsigned        frame;
        int unsigned        lvl;
        int unsigned        pos;
        logic               unmap;
        r       = '0;
        r.status = ST_DONE;
        unmap   = (w.req_type == REQ_UNMAP);
        link[0] = w.top_flags;
        link[1] = w.mid_flags;
        link[2] = w.low_flags;
        frame   = 0;
        if (w.virt_addr[PG_W-1:0] != '0 || (!unmap && w.phys_addr[PG_W-1:0] != '0)) begin
            r.status = ST_UNALIGNED;
        end else begin
            for (lvl = 0; lvl < 3 && r.status == ST_DONE; lvl++) begin
                slot  = w.virt_addr[39 - 9 * lvl +: IDX_W];
                pos   = frame * SLOTS + slot;
                entry = frame_mem[pos];
                if (entry == '0) begin
                    if (unmap) begin
                        r.status = ST_NOT_MAPPED;
                    end else if (frames_used >= TABLE_FRAMES) begin
                        r.status = ST_NO_FRAMES;
                    end else begin
                        for (int k = 0; k < SLOTS; k++) frame_mem[frames_used * SLOTS + k] = '0;
                        frame_mem[pos] = {12'h000, base_pfn + PFN_W'(frames_used), 12'h000}
                                         | link[lvl];
                        frame = frames_used;
                        frames_used++;
                    end
                end else begin
                    // only address bits 12..51 form the pointer
                    rel = entry[51:12] - base_pfn;
                    if (rel >= PFN_W'(TABLE_FRAMES)) r.status = ST_BAD_POINTER;
                    else frame = 32'(rel);
                end
            end
            if (r.status == ST_DONE) begin
                pos = frame * SLOTS + w.virt_addr[20:12];
                if (unmap) begin
                    if (frame_mem[pos] == '0) begin
                        r.status = ST_NOT_MAPPED;
                    end else begin
                        frame_mem[pos] = '0;
                        r.invalidate   = 1'b1;
                    end
                end else if (frame_mem[pos] == '0 || w.allow_override) begin
                    frame_mem[pos] = {12'h000, w.phys_addr} | w.page_flags;
                    r.invalidate   = 1'b1;
                end else begin
                    r.status = ST_REFUSED;
                end
            end
        end
        if (r.invalidate) r.inv_addr = w.virt_addr;
        return r;
    endfunction

    function automatic map_req_t random_word();
        map_req_t          w;
        logic [63:0]       r64;
        logic [26:0]       prefix;
        logic [IDX_W-1:0]  s3;
        int unsigned       pick;
        w.req_type = ($urandom_range(0, 99) < 55) ? REQ_MAP : REQ_UNMAP;
        if ($urandom_range(0, 9) < 7) begin
            s3 = ($urandom_range(0, 1) != 0) ? 9'($urandom_range(0, 3))
                                             : 9'($urandom_range(508, 511));
        end else begin
            s3 = 9'($urandom_range(0, 511));
        end
        case ($urandom_range(0, 5))
            0:       prefix = {9'd0,   9'd0,   9'd0};
            1:       prefix = {9'd511, 9'd511, 9'd511};
            2:       prefix = {9'd511, 9'd511, 9'd0};
            3:       prefix = {9'd511, 9'd511, 9'd1};
            4:       prefix = {9'd1,   9'd0,   9'd0};
            default: prefix = {9'd2,   9'd0,   9'd0};
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            w.virt_addr = {prefix, s3, 12'h000};
        end else if (pick < 95) begin
            w.virt_addr = {corner_slot(), corner_slot(), corner_slot(), s3, 12'h000};
        end else begin
            r64         = {$urandom, $urandom};
            w.virt_addr = {r64[47:12], 12'h000};
        end
        if ($urandom_range(0, 99) < 5) w.virt_addr[11:0] = 12'($urandom_range(1, 4095));
        r64         = {$urandom, $urandom};
        w.phys_addr = r64[51:0];
        if ($urandom_range(0, 99) >= 5) w.phys_addr[11:0] = '0;
        w.top_flags      = {$urandom, $urandom};
        w.mid_flags      = {$urandom, $urandom};
        w.low_flags      = {$urandom, $urandom};
        w.page_flags     = {$urandom, $urandom};
        w.allow_override = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic void set_pace(input pace_t p);
        src_gap_pct   = (p == PACE_SRC_GAPS) ? 68 : (p == PACE_BOTH) ? 12 : 0;
        snk_stall_pct = (p == PACE_SNK_STALL) ? 68 : (p == PACE_BOTH) ? 12 : 0;
    endfunction

    task automatic send_word(input map_req_t w, input logic typed, input walk_result_t want);
        walk_result_t got;
        @(negedge i_clk);
        while (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            req_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid          = 1'b1;
        req_bus.req_type       = w.req_type;
        req_bus.virt_addr      = w.virt_addr;
        req_bus.phys_addr      = w.phys_addr;
        req_bus.top_link_flags = w.top_flags;
        req_bus.mid_link_flags = w.mid_flags;
        req_bus.low_link_flags = w.low_flags;
        req_bus.page_flags     = w.page_flags;
        req_bus.allow_override = w.allow_override;
        do @(posedge i_clk); while (!req_bus.ready);
        got = walk_tables(w);
        walk_results_q.push_back(typed ? want : got);
        words_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        while (walk_results_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_table_base(input logic [PFN_W-1:0] v);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_data = v;
        @(negedge i_clk);
        cfg_we   = 1'b0;
        base_pfn = v;
    endtask

    always @(negedge i_clk) begin
        rsp_bus.ready = !(snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct);
    end

    always @(posedge i_clk) begin : rsp_check
        walk_result_t want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            words_checked++;
            status_seen[rsp_bus.status]++;
            if (walk_results_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected response word: status %0d inval %0b addr %h",
                             rsp_bus.status, rsp_bus.invalidate, rsp_bus.invalidate_addr);
            end else begin
                want = walk_results_q.pop_front();
                if (rsp_bus.status !== want.status || rsp_bus.invalidate !== want.invalidate
                    || rsp_bus.invalidate_addr !== want.inv_addr) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("word %0d mismatch: status %0d/%0d inval %0b/%0b addr %h/%h",
                                 words_checked, want.status, rsp_bus.status,
                                 want.invalidate, rsp_bus.invalidate,
                                 want.inv_addr, rsp_bus.invalidate_addr);
                end
            end
        end
    end

    initial begin
        map_req_t         w;
        logic [63:0]      r64;
        logic [PFN_W-1:0] next_base;
        int unsigned      n_directed;
        i_rst_n                = 1'b0;
        cfg_we                 = 1'b0;
        cfg_data               = '0;
        req_bus.valid          = 1'b0;
        req_bus.req_type       = REQ_MAP;
        req_bus.virt_addr      = '0;
        req_bus.phys_addr      = '0;
        req_bus.top_link_flags = '0;
        req_bus.mid_link_flags = '0;
        req_bus.low_link_flags = '0;
        req_bus.page_flags     = '0;
        req_bus.allow_override = 1'b0;
        for (int k = 0; k < DEPTH; k++) frame_mem[k] = '0;
        frames_used = 1;
        base_pfn    = BASE_RESET;
        set_pace(PACE_FREE);

        // error codes on an empty store
        add_row(REQ_UNMAP, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1, ST_NOT_MAPPED, 1'b0);
        add_row(REQ_MAP, 48'h1, '0, '0, '0, '0, '0, 1'b0, 1'b1, ST_UNALIGNED, 1'b0);
        add_row(REQ_MAP, '0, 52'h800, '0, '0, '0, '0, 1'b0, 1'b1, ST_UNALIGNED, 1'b0);
        add_row(REQ_UNMAP, 48'h800, '0, '0, '0, '0, '0, 1'b0, 1'b1, ST_UNALIGNED, 1'b0);
        add_row(REQ_UNMAP, va_of(0, 0, 0, 1), 52'hFFF, '0, '0, '0, '0, 1'b0, 1'b1,
                ST_NOT_MAPPED, 1'b0);
        // with base at its max the first root link is an all-zero entry
        add_row(REQ_MAP, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1, ST_DONE, 1'b1);
        add_row(REQ_MAP, '0, PA_TOP, '0, '0, '0, '0, 1'b0, 1'b0, ST_DONE, 1'b0);
        add_row(REQ_MAP, '0, 52'h1000, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0, 1'b1,
                ST_REFUSED, 1'b0);
        add_row(REQ_MAP, '0, 52'h1000, '0, '0, '0, ALL_ONES, 1'b1, 1'b1, ST_DONE, 1'b1);
        add_row(REQ_UNMAP, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1, ST_DONE, 1'b1);
        add_row(REQ_UNMAP, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1, ST_NOT_MAPPED, 1'b0);
        add_row(REQ_MAP, va_of(511, 511, 511, 511), PA_TOP, NO_ADDR_BITS, NO_ADDR_BITS,
                NO_ADDR_BITS, ALL_ONES, 1'b0, 1'b1, ST_DONE, 1'b1);
        add_row(REQ_MAP, va_of(511, 511, 511, 510), 52'h5_A5A5_A5A5_A000, '0, '0, '0,
                64'h8000_0000_0000_0001, 1'b1, 1'b0, ST_DONE, 1'b0);
        add_row(REQ_UNMAP, va_of(511, 511, 511, 511), '0, '0, '0, '0, '0, 1'b0, 1'b1,
                ST_DONE, 1'b1);
        // link flags that touch address bits corrupt the pointer
        add_row(REQ_MAP, va_of(511, 511, 0, 0), 52'h1000, '0, '0, PFN_BIT12, 64'h3, 1'b0,
                1'b0, ST_DONE, 1'b0);
        add_row(REQ_MAP, va_of(511, 511, 0, 1), 52'h2000, '0, '0, '0, '0, 1'b0, 1'b0,
                ST_DONE, 1'b0);
        add_row(REQ_MAP, va_of(511, 511, 1, 0), 52'h3000, '0, '0, 64'h7, 64'h5, 1'b0, 1'b0,
                ST_DONE, 1'b0);
        add_row(REQ_MAP, va_of(1, 0, 0, 0), 52'h4000, 64'h7, 64'h3, 64'h1, 64'h63, 1'b0,
                1'b0, ST_DONE, 1'b0);
        // frames run out part way through a walk
        add_row(REQ_MAP, va_of(2, 0, 0, 0), 52'h5000, 64'h3, 64'h3, 64'h3, 64'h3, 1'b0,
                1'b0, ST_DONE, 1'b0);
        add_row(REQ_UNMAP, va_of(2, 0, 0, 0), '0, '0, '0, '0, '0, 1'b0, 1'b0, ST_DONE, 1'b0);
        add_row(REQ_MAP, va_of(2, 0, 0, 0), 52'h6000, '0, '0, '0, '0, 1'b1, 1'b0,
                ST_DONE, 1'b0);
        add_row(REQ_MAP, va_of(3, 0, 0, 0), 52'h7000, '0, '0, '0, '0, 1'b0, 1'b1,
                ST_NO_FRAMES, 1'b0);
        add_row(REQ_UNMAP, va_of(511, 511, 511, 510), '0, '0, '0, '0, '0, 1'b0, 1'b0,
                ST_DONE, 1'b0);
        n_directed = directed_rows.size();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_table_base(BASE_MAX);
        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: next_base = BASE_MAX;
                1: next_base = '0;
                2: begin
                    r64       = {$urandom, $urandom};
                    next_base = r64[PFN_W-1:0];
                end
                3: next_base = BASE_MAX - 1'b1;
                4: next_base = BASE_RESET;
                default: next_base = BASE_MAX;
            endcase
            write_table_base(next_base);
            set_pace(pace_t'(p < 4 ? p : p - 3));
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                w = random_word();
                send_word(w, 1'b0, '0);
            end
            drain_results();
        end

        set_pace(PACE_FREE);
        repeat (40) @(posedge i_clk);

        $display("page walk run: %0d requests (%0d directed, %0d phases of base and pacing),",
                 words_sent, n_directed, N_PHASES);
        $display("  %0d responses: done %0d refused %0d unaligned %0d no-frames %0d %s %0d %s %0d",
                 words_checked, status_seen[ST_DONE], status_seen[ST_REFUSED],
                 status_seen[ST_UNALIGNED], status_seen[ST_NO_FRAMES], "not-mapped",
                 status_seen[ST_NOT_MAPPED], "bad-pointer", status_seen[ST_BAD_POINTER]);
        if (err_count == 0 && walk_results_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/ptm_pkg.sv
rtl/ptm_req_if.sv
rtl/ptm_rsp_if.sv
rtl/ptm_ram.sv
rtl/ptm_useq.sv
rtl/ptm_dpath.sv
rtl/page_table_map_unmap.sv
tb/page_table_map_unmap_tb.sv
